// ----- src/npc_pkg.sv -----
package npc_pkg;

    localparam int DEFAULT_PALETTE_ENTRIES = 256;
    localparam int WRITABLE_ENTRIES        = 256;
    localparam int CH_W                    = 8;
    localparam int IDX_W                   = 8;
    localparam int SQ_W                    = 16;
    localparam int DIST_W                  = 18;

    localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } color_t;

    // travels with each palette entry through the read/distance pipeline
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

// ----- src/nearest_palette_color.sv -----
// Nearest palette color search. A write transaction (cmd=0) stores one RGB entry and
// gives no result; slots at or above PALETTE_ENTRIES, and above 255, are never written
// and read as zero. A query transaction (cmd=1) scans every slot in order, one palette
// memory read per cycle, through a three-stage distance pipeline, and returns the
// lowest-index slot with the least squared RGB distance. A query holds the input off
// until its result is in the output register; a write leaves the input ready. The
// palette is cleared by reset with no clearing pass. A finished result waits in the
// output register while the next transaction is taken.
module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = npc_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [npc_pkg::IDX_W-1:0]    entry_index,
    input  logic [npc_pkg::CH_W-1:0]     red,
    input  logic [npc_pkg::CH_W-1:0]     green,
    input  logic [npc_pkg::CH_W-1:0]     blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [npc_pkg::IDX_W-1:0]    closest_index,
    output logic [npc_pkg::DIST_W-1:0]   distance_squared
);
    import npc_pkg::*;

    localparam int MEM_DEPTH = (PALETTE_ENTRIES < WRITABLE_ENTRIES) ?
                               PALETTE_ENTRIES : WRITABLE_ENTRIES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(PALETTE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg,  state_next;
    logic              issue_reg,  issue_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    color_t            color_reg,  color_next;
    logic [IDX_W-1:0]  best_idx_reg,  best_idx_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg,   out_idx_next;
    logic [DIST_W-1:0] out_dist_reg,  out_dist_next;

    logic              in_accept;
    logic              wr_en;
    color_t            in_color;
    tag_t              rd_tag;
    logic              rd_zero;
    color_t            mem_data;
    tag_t              mem_tag;
    logic [DIST_W-1:0] d_dist;
    tag_t              d_tag;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign in_color  = '{r: red, g: green, b: blue};
    assign wr_en     = in_accept && (cmd == CMD_WRITE) &&
                       (32'(entry_index) < 32'(PALETTE_ENTRIES));

    assign rd_tag.vld   = issue_reg;
    assign rd_tag.first = (cnt_reg == '0);
    assign rd_tag.last  = (cnt_reg == CNT_LAST);
    assign rd_tag.idx   = IDX_W'(cnt_reg);
    assign rd_zero      = (32'(cnt_reg) >= 32'(MEM_DEPTH));

    npc_palette_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .MEM_AW    (MEM_AW)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (entry_index[MEM_AW-1:0]),
        .wr_data    (in_color),
        .rd_addr    (cnt_reg[MEM_AW-1:0]),
        .rd_zero    (rd_zero),
        .rd_tag     (rd_tag),
        .rd_data    (mem_data),
        .rd_tag_out (mem_tag)
    );

    npc_distance u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .color   (color_reg),
        .entry   (mem_data),
        .tag_in  (mem_tag),
        .dist_sq (d_dist),
        .tag_out (d_tag)
    );

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        cnt_next       = cnt_reg;
        color_next     = color_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;

        // strict less-than keeps the lowest index on ties
        if (d_tag.vld && (d_tag.first || (d_dist < best_dist_reg)))
        begin
            best_idx_next  = d_tag.idx;
            best_dist_next = d_dist;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (cmd == CMD_QUERY))
                begin
                    color_next = in_color;
                    cnt_next   = '0;
                    issue_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (d_tag.vld && d_tag.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = best_idx_reg;
                    out_dist_next  = best_dist_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                issue_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        out_idx_reg   <= out_idx_next;
        out_dist_reg  <= out_dist_next;
    end

    assign out_valid        = out_valid_reg;
    assign closest_index    = out_idx_reg;
    assign distance_squared = out_dist_reg;

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished scan");

    a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        d_tag.vld |-> (state_reg == ST_SCAN))
        else $error("distance pipeline active outside a scan");

    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!issue_reg && !mem_tag.vld && !d_tag.vld))
        else $error("palette write overlaps a scan");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance_squared <= MAX_DIST))
        else $error("distance out of range");

endmodule

// ----- src/npc_palette_mem.sv -----
module npc_palette_mem #(
    parameter int MEM_DEPTH = npc_pkg::WRITABLE_ENTRIES,
    parameter int MEM_AW    = $clog2(MEM_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [MEM_AW-1:0]  wr_addr,
    input  npc_pkg::color_t    wr_data,
    input  logic [MEM_AW-1:0]  rd_addr,
    input  logic               rd_zero,
    input  npc_pkg::tag_t      rd_tag,
    output npc_pkg::color_t    rd_data,
    output npc_pkg::tag_t      rd_tag_out
);
    import npc_pkg::*;

    color_t               mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    color_t               rd_raw_reg;
    logic                 rd_vld_reg;
    tag_t                 tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            tag_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr] && !rd_zero;
            tag_reg    <= rd_tag;
        end
    end

    // never-written entries read as zero
    assign rd_data    = rd_vld_reg ? rd_raw_reg : '0;
    assign rd_tag_out = tag_reg;

endmodule

// ----- src/npc_distance.sv -----
module npc_distance (
    input  logic                         clk,
    input  logic                         rst_n,
    input  npc_pkg::color_t              color,
    input  npc_pkg::color_t              entry,
    input  npc_pkg::tag_t                tag_in,
    output logic [npc_pkg::DIST_W-1:0]   dist_sq,
    output npc_pkg::tag_t                tag_out
);
    import npc_pkg::*;

    color_t            diff_reg;
    logic [SQ_W-1:0]   sq_r_reg;
    logic [SQ_W-1:0]   sq_g_reg;
    logic [SQ_W-1:0]   sq_b_reg;
    logic [DIST_W-1:0] dist_reg;
    tag_t              tag1_reg;
    tag_t              tag2_reg;
    tag_t              tag3_reg;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    always_ff @(posedge clk)
    begin
        diff_reg.r <= abs_diff(color.r, entry.r);
        diff_reg.g <= abs_diff(color.g, entry.g);
        diff_reg.b <= abs_diff(color.b, entry.b);
        sq_r_reg   <= SQ_W'(diff_reg.r) * SQ_W'(diff_reg.r);
        sq_g_reg   <= SQ_W'(diff_reg.g) * SQ_W'(diff_reg.g);
        sq_b_reg   <= SQ_W'(diff_reg.b) * SQ_W'(diff_reg.b);
        dist_reg   <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign dist_sq = dist_reg;
    assign tag_out = tag3_reg;

endmodule
